@@ src/wrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_pkg
// Shared widths, request types, command/status groups and controller states
// for the 96-bit restoring divider.
// ----------------------------------------------------------------------------
package wrd_pkg;

	localparam int WORD_W = 32;
	localparam int DATA_W = 96;
	localparam int REM_W  = DATA_W + 1;
	localparam int STEP_W = 7;

	// index of the final step, one quotient bit per step
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

	typedef struct packed {
		logic [WORD_W-1:0] dividend_w0;
		logic [WORD_W-1:0] dividend_w1;
		logic [WORD_W-1:0] dividend_w2;
		logic [WORD_W-1:0] divisor_w0;
		logic [WORD_W-1:0] divisor_w1;
		logic [WORD_W-1:0] divisor_w2;
	} in_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] quotient_w0;
		logic [WORD_W-1:0] quotient_w1;
		logic [WORD_W-1:0] quotient_w2;
		logic [WORD_W-1:0] remainder_w0;
		logic [WORD_W-1:0] remainder_w1;
		logic [WORD_W-1:0] remainder_w2;
		logic              divide_by_zero;
	} out_req_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic out_load;
		logic out_from_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_step;
	} sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

endpackage

@@ src/wide_restoring_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_restoring_divider
// Unsigned 96-bit by 96-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: operands load at the accept edge, then the step cycles run; the
// result loads with the last step, or once the output register frees.
// Requests are taken only when idle, as the single shared 97-bit subtract/compare
// step unit serves every step; the next request is taken while a result waits.
// Zero divisor: quotient all ones, remainder = dividend, divide_by_zero set.
// Reset: arst_n clears the sequencer, step counter and result valid flag.
// ----------------------------------------------------------------------------
module wide_restoring_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wrd_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output wrd_pkg::out_req_t out_data
);
	import wrd_pkg::*;

	cmd_t cmd;
	sts_t status;

	wrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	wrd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.status   (status),
		.out_data (out_data)
	);

	// divide by zero always yields an all-ones quotient
	a_zero_quot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |->
			out_data.quotient_w0 == '1 && out_data.quotient_w1 == '1 &&
			out_data.quotient_w2 == '1)
		else $error("divide by zero quotient not all ones");

endmodule

@@ src/wrd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_datapath
// Partial remainder, quotient shift register, divisor hold, step counter and
// the result register. One restoring step per cycle when commanded.
// ----------------------------------------------------------------------------
module wrd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  wrd_pkg::cmd_t     cmd,
	input  wrd_pkg::in_req_t  in_data,
	output wrd_pkg::sts_t     status,
	output wrd_pkg::out_req_t out_data
);
	import wrd_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] div_q;
	logic              zero_q;
	logic [STEP_W-1:0] cnt_q;
	out_req_t          out_q;

	logic [DATA_W-1:0] in_dividend;
	logic [DATA_W-1:0] in_divisor;
	logic [REM_W-1:0]  shifted;
	logic [REM_W:0]    diff;
	logic              ge;
	logic [REM_W-1:0]  rem_next;
	logic [DATA_W-1:0] quo_next;
	logic [DATA_W-1:0] res_quo;
	logic [DATA_W-1:0] res_rem;

	assign in_dividend = {in_data.dividend_w2, in_data.dividend_w1, in_data.dividend_w0};
	assign in_divisor  = {in_data.divisor_w2, in_data.divisor_w1, in_data.divisor_w0};

	// one restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		shifted  = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
		diff     = {1'b0, shifted} - {2'b00, div_q};
		ge       = ~diff[REM_W];
		rem_next = ge ? diff[REM_W-1:0] : shifted;
		quo_next = {quo_q[DATA_W-2:0], ge};
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= '0;
			quo_q  <= in_dividend;
			div_q  <= in_divisor;
			zero_q <= (in_divisor == '0);
		end else if (cmd.step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + STEP_W'(1);
		end
	end

	assign status.last_step = (cnt_q == LAST_STEP);

	// result source: the final step directly, or the settled registers
	always_comb begin
		res_quo = cmd.out_from_step ? quo_next : quo_q;
		res_rem = cmd.out_from_step ? rem_next[DATA_W-1:0] : rem_q[DATA_W-1:0];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.quotient_w0    <= res_quo[WORD_W-1:0];
			out_q.quotient_w1    <= res_quo[2*WORD_W-1:WORD_W];
			out_q.quotient_w2    <= res_quo[3*WORD_W-1:2*WORD_W];
			out_q.remainder_w0   <= res_rem[WORD_W-1:0];
			out_q.remainder_w1   <= res_rem[2*WORD_W-1:WORD_W];
			out_q.remainder_w2   <= res_rem[3*WORD_W-1:2*WORD_W];
			out_q.divide_by_zero <= zero_q;
		end
	end

	assign out_data = out_q;

endmodule

@@ src/wrd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrd_ctrl
// Sequencer for the divider: takes a request, runs the step cycles and hands
// the result to the output register, holding it back while that is full.
// ----------------------------------------------------------------------------
module wrd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  wrd_pkg::sts_t status,
	output wrd_pkg::cmd_t cmd
);
	import wrd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = ~out_valid_q | ~out_stall;
	assign accept   = in_valid & (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.last_step) state_d = out_free ? ST_IDLE : ST_WAIT;
			end
			ST_WAIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		in_stall          = 1'b1;
		cmd.load          = 1'b0;
		cmd.step          = 1'b0;
		cmd.out_load      = 1'b0;
		cmd.out_from_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = accept;
			end
			ST_RUN: begin
				cmd.step          = 1'b1;
				cmd.out_from_step = 1'b1;
				cmd.out_load      = status.last_step & out_free;
			end
			ST_WAIT: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// waiting only happens behind a full output register
	a_wait_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> out_valid_q)
		else $error("wait state without pending result");

	// an accepted request starts the step sequence
	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN)
		else $error("accepted request did not start");

	// the sequence runs until the last step
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !status.last_step |=> state_q == ST_RUN)
		else $error("step sequence left early");

	// a new result only comes from a running or waiting division
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state_q == ST_RUN || state_q == ST_WAIT)
		else $error("result loaded while idle");

endmodule

@@ bench/wide_restoring_divider_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_restoring_divider_tb
// Self-checking bench for the 96-bit unsigned restoring divider. Requests go
// in through a valid/stall handshake. Each accepted request is predicted with
// a bit-serial restoring division and queued. Every result taken at the output
// is compared field by field with the oldest queued quotient, remainder and zero flag.
// Directed corner cases run first, then shaped random operands with random
// idling on both sides and one long back-to-back stretch.
// ----------------------------------------------------------------------------
module wide_restoring_divider_tb;
	import wrd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_PCT    = 26;
	localparam int DRAIN_WAIT  = 110;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	in_req_t  in_data;
	logic     out_valid;
	logic     out_stall = 1'b0;
	out_req_t out_data;

	out_req_t quotients_due[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       idling = 1'b1;

	wide_restoring_divider uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// bit-serial restoring division with a 97-bit partial remainder
	function automatic out_req_t divide_restoring(input in_req_t req);
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] dvs;
		logic [REM_W-1:0]  rem;
		out_req_t          res;
		int                i;
		quo = {req.dividend_w2, req.dividend_w1, req.dividend_w0};
		dvs = {req.divisor_w2, req.divisor_w1, req.divisor_w0};
		rem = '0;
		for (i = 0; i < DATA_W; i++) begin
			rem = {rem[REM_W-2:0], quo[DATA_W-1]};
			quo = {quo[DATA_W-2:0], 1'b0};
			if (rem >= {1'b0, dvs}) begin
				rem = rem - {1'b0, dvs};
				quo[0] = 1'b1;
			end
		end
		res.quotient_w0    = quo[WORD_W-1:0];
		res.quotient_w1    = quo[2*WORD_W-1:WORD_W];
		res.quotient_w2    = quo[DATA_W-1:2*WORD_W];
		res.remainder_w0   = rem[WORD_W-1:0];
		res.remainder_w1   = rem[2*WORD_W-1:WORD_W];
		res.remainder_w2   = rem[DATA_W-1:2*WORD_W];
		res.divide_by_zero = (dvs == '0);
		return res;
	endfunction

	function automatic in_req_t pack_operands(input logic [DATA_W-1:0] dividend,
			input logic [DATA_W-1:0] divisor);
		in_req_t req;
		req.dividend_w0 = dividend[WORD_W-1:0];
		req.dividend_w1 = dividend[2*WORD_W-1:WORD_W];
		req.dividend_w2 = dividend[DATA_W-1:2*WORD_W];
		req.divisor_w0  = divisor[WORD_W-1:0];
		req.divisor_w1  = divisor[2*WORD_W-1:WORD_W];
		req.divisor_w2  = divisor[DATA_W-1:2*WORD_W];
		return req;
	endfunction

	// operand with a random bit length, sometimes top bit forced
	function automatic logic [DATA_W-1:0] random_operand();
		logic [DATA_W-1:0] v;
		v = {$urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: v = v >> $urandom_range(0, DATA_W - 1);
			2: v = v >> $urandom_range(2 * WORD_W, DATA_W - 1);
			3: v[DATA_W-1] = 1'b1;
			4: v = v >> $urandom_range(WORD_W, 2 * WORD_W);
			default: ;
		endcase
		return v;
	endfunction

	// present one request, hold it until accepted, queue its prediction
	task automatic issue_division(input in_req_t req);
		if (idling && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 150)) @(posedge clk);
		end
		while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			in_data  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		quotients_due.push_back(divide_restoring(req));
	endtask

	task automatic issue_operands(input logic [DATA_W-1:0] dividend,
			input logic [DATA_W-1:0] divisor);
		issue_division(pack_operands(dividend, divisor));
	endtask

	// corner cases: zero divisor, top-bit divisors, small over large, extremes
	task automatic test_corner_cases();
		logic [DATA_W-1:0] ones;
		logic [DATA_W-1:0] top;
		logic [DATA_W-1:0] alt;
		ones = '1;
		top  = '0;
		top[DATA_W-1] = 1'b1;
		alt  = {(DATA_W / 2){2'b10}};
		issue_operands('0, '0);
		issue_operands(ones, '0);
		issue_operands({$urandom, $urandom, $urandom}, '0);
		issue_operands(ones, 96'd1);
		issue_operands(ones, ones);
		issue_operands('0, ones);
		issue_operands(ones, top);
		issue_operands(ones, top | 96'd1);
		issue_operands(top | 96'd5, top | 96'd3);
		issue_operands(top | 96'd3, top | 96'd5);
		issue_operands(96'd5, 96'd7);
		issue_operands(96'd1, 96'd1);
		issue_operands(ones, 96'd3);
		issue_operands(96'd1 << 64, 96'd1 << 32);
		issue_operands(ones, 96'hFFFF_FFFF);
		issue_operands(alt, ~alt);
		issue_operands(~alt, alt);
		issue_operands(top, 96'd1);
		issue_operands((96'd1 << 64) - 96'd1, 96'hFFFF_FFFF);
		issue_operands(96'h0123_4567_89AB_CDEF_FEDC_BA98, (96'd1 << 64) | 96'd1);
		issue_operands(96'd1, ones);
		issue_operands(ones - 96'd1, ones);
	endtask

	// shaped random operand pairs
	task automatic test_random_operands(input int count);
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] swap;
		repeat (count) begin
			dividend = random_operand();
			divisor  = random_operand();
			case ($urandom_range(0, 19))
				0: divisor = '0;
				1: divisor = dividend;
				2: begin
					if (dividend > divisor) begin
						swap     = dividend;
						dividend = divisor;
						divisor  = swap;
					end
				end
				3: divisor = DATA_W'($urandom_range(1, 15));
				4: dividend = '1;
				default: ;
			endcase
			issue_operands(dividend, divisor);
		end
	endtask

	// both sides run without idling
	task automatic test_back_to_back(input int count);
		idling = 1'b0;
		test_random_operands(count);
		idling = 1'b1;
	endtask

	// result checking and receiver stalls
	task automatic check_field(input string label, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		out_req_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wide_restoring_divider_tb: errors");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (quotients_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h",
					$time, out_data);
				mismatch_count++;
			end else begin
				want = quotients_due.pop_front();
				check_field("quotient_w0", want.quotient_w0, out_data.quotient_w0);
				check_field("quotient_w1", want.quotient_w1, out_data.quotient_w1);
				check_field("quotient_w2", want.quotient_w2, out_data.quotient_w2);
				check_field("remainder_w0", want.remainder_w0, out_data.remainder_w0);
				check_field("remainder_w1", want.remainder_w1, out_data.remainder_w1);
				check_field("remainder_w2", want.remainder_w2, out_data.remainder_w2);
				check_field("divide_by_zero", WORD_W'(want.divide_by_zero),
					WORD_W'(out_data.divide_by_zero));
			end
		end
		out_stall <= idling && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// test sequence
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_operands(500);
		test_back_to_back(250);
		test_random_operands(430);

		in_valid <= 1'b0;
		while (quotients_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("wide_restoring_divider_tb: clean");
		end else begin
			$display("wide_restoring_divider_tb: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/wrd_pkg.sv
src/wrd_datapath.sv
src/wrd_ctrl.sv
src/wide_restoring_divider.sv
bench/wide_restoring_divider_tb.sv
